// ===== design/adc_pkg.sv =====
// Shared types, constants and helper functions of the aim direction correction block.
package adc_pkg;

  localparam int unsigned DIR_FRAC_BITS   = 14;
  localparam int unsigned ANGLE_FRAC_BITS = 13;
  localparam int unsigned ID_WIDTH        = 32;
  localparam int unsigned CORDIC_STEPS    = 16;
  localparam int unsigned CORDIC_CNT_W    = $clog2(CORDIC_STEPS);
  localparam int unsigned CORDIC_W        = 36;
  localparam int unsigned ANG_W           = 18;
  localparam int unsigned GUARD_SHIFT     = 16;
  localparam int unsigned SQRT_STEPS      = 32;

  localparam logic signed [ANG_W-1:0] ANG_PI      = 18'sd25736;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 18'sd12868;
  localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 18'sd51472;

  localparam logic [31:0] LSQ_LO = 32'd1 << (2 * DIR_FRAC_BITS - 2);
  localparam logic [31:0] LSQ_HI = 32'd9 << (2 * DIR_FRAC_BITS - 2);

  localparam logic [1:0] CFG_GAIN     = 2'd0;
  localparam logic [1:0] CFG_DEADZONE = 2'd1;
  localparam logic [1:0] CFG_LIMIT    = 2'd2;
  localparam logic [1:0] CFG_MIN_HOR  = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_XX, ST_ZZ, ST_YY, ST_MM, ST_MMW, ST_PLO, ST_PHI, ST_PADD,
    ST_CYAW, ST_CYAW_WAIT, ST_SQRT_WAIT, ST_CPIT_WAIT, ST_ERR, ST_DX, ST_DY,
    ST_DYF, ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    MUL_XX, MUL_ZZ, MUL_YY, MUL_MM, MUL_PLO, MUL_PHI, MUL_DX, MUL_DY
  } mul_op_e;

  typedef enum logic [3:0] {
    TK_NONE, TK_HSQ_SET, TK_HSQ_ADD, TK_LSQ, TK_MM, TK_P_SET, TK_P_ADD,
    TK_YANG, TK_TY, TK_TP, TK_ERR, TK_DX, TK_DY
  } take_e;

  typedef struct packed {
    logic    load;
    mul_op_e mul_op;
    take_e   take;
    logic    sqrt_start;
    logic    cordic_start;
    logic    cordic_pitch;
    logic    commit;
  } cmd_t;

  typedef struct packed {
    logic sqrt_busy;
    logic cordic_busy;
  } status_t;

  function automatic logic signed [15:0] wrap_angle(input logic signed [ANG_W-1:0] v);
    logic signed [ANG_W-1:0] r;
    begin
      r = v;
      if (v > ANG_PI) begin
        r = v - ANG_TWO_PI;
      end else if (v <= -ANG_PI) begin
        r = v + ANG_TWO_PI;
      end
      return r[15:0];
    end
  endfunction

  function automatic logic [15:0] atan_entry(input logic [4:0] i);
    logic [31:0] q;
    logic [31:0] r;
    begin
      case (i)
        5'd0:  q = 32'd843314857;
        5'd1:  q = 32'd497837829;
        5'd2:  q = 32'd263043837;
        5'd3:  q = 32'd133525159;
        5'd4:  q = 32'd67021687;
        5'd5:  q = 32'd33543516;
        5'd6:  q = 32'd16775851;
        5'd7:  q = 32'd8388437;
        5'd8:  q = 32'd4194283;
        5'd9:  q = 32'd2097149;
        5'd10: q = 32'd1048576;
        5'd11: q = 32'd524288;
        5'd12: q = 32'd262144;
        5'd13: q = 32'd131072;
        5'd14: q = 32'd65536;
        5'd15: q = 32'd32768;
        5'd16: q = 32'd16384;
        5'd17: q = 32'd8192;
        5'd18: q = 32'd4096;
        5'd19: q = 32'd2048;
        5'd20: q = 32'd1024;
        5'd21: q = 32'd512;
        5'd22: q = 32'd256;
        5'd23: q = 32'd128;
        5'd24: q = 32'd64;
        5'd25: q = 32'd32;
        5'd26: q = 32'd16;
        5'd27: q = 32'd8;
        5'd28: q = 32'd4;
        5'd29: q = 32'd2;
        5'd30: q = 32'd1;
        default: q = 32'd0;
      endcase
      r = (q + (32'd1 << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS);
      return r[15:0];
    end
  endfunction

endpackage

// ===== design/aim_direction_correction_top.sv =====
// Top level of the aim direction correction block.
//
// Input channel: in_valid_i / in_stall_o with the direction, present angles,
// identifiers and sequence number. A request is taken when valid is high and
// stall is low; the block holds one request at a time and stalls otherwise.
// Output channel: out_valid_o / out_stall_i with one result per request.
// From acceptance to out_valid_o a request passes the squaring multiplies,
// the bit-serial square root, then the 16-step pitch CORDIC and the error
// and drive math (the yaw CORDIC overlaps the root). A new request is taken
// only once the previous result has been committed to the output register.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls, the following result waits in the last
// step until the register is free.
// Config: cfg_valid_i / cfg_ready_o (always ready), index 0 gain, 1 deadzone,
// 2 drive limit, 3 minimum horizontal; write only while idle.
// Reset (asynchronous, active low) restores the config defaults and clears the
// held identifiers and last sequence number.
module aim_direction_correction_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [15:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         enable_i,
  input  logic                         target_tracked_i,
  input  logic signed [15:0]           dir_x_i,
  input  logic signed [15:0]           dir_y_i,
  input  logic signed [15:0]           dir_z_i,
  input  logic signed [15:0]           current_yaw_i,
  input  logic signed [15:0]           current_pitch_i,
  input  logic [adc_pkg::ID_WIDTH-1:0] body_id_i,
  input  logic [adc_pkg::ID_WIDTH-1:0] item_id_i,
  input  logic [63:0]                  sequence_number_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         target_accepted_o,
  output logic                         ids_captured_o,
  output logic signed [15:0]           wrapped_yaw_o,
  output logic signed [15:0]           passed_pitch_o,
  output logic signed [15:0]           target_yaw_o,
  output logic signed [14:0]           target_pitch_o,
  output logic signed [15:0]           yaw_error_o,
  output logic signed [16:0]           pitch_error_o,
  output logic signed [15:0]           drive_x_o,
  output logic signed [15:0]           drive_y_o
);

  adc_pkg::cmd_t    cmd;
  adc_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  adc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  adc_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .enable_i          (enable_i),
    .target_tracked_i  (target_tracked_i),
    .dir_x_i           (dir_x_i),
    .dir_y_i           (dir_y_i),
    .dir_z_i           (dir_z_i),
    .current_yaw_i     (current_yaw_i),
    .current_pitch_i   (current_pitch_i),
    .body_id_i         (body_id_i),
    .item_id_i         (item_id_i),
    .sequence_number_i (sequence_number_i),
    .target_accepted_o (target_accepted_o),
    .ids_captured_o    (ids_captured_o),
    .wrapped_yaw_o     (wrapped_yaw_o),
    .passed_pitch_o    (passed_pitch_o),
    .target_yaw_o      (target_yaw_o),
    .target_pitch_o    (target_pitch_o),
    .yaw_error_o       (yaw_error_o),
    .pitch_error_o     (pitch_error_o),
    .drive_x_o         (drive_x_o),
    .drive_y_o         (drive_y_o)
  );

endmodule

// ===== design/adc_sqrt.sv =====
// Bit-serial integer square root of a 32-bit value shifted up by 32 bits.
module adc_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] rad_i,
  output logic        busy_o,
  output logic [31:0] root_o
);

  localparam int unsigned CNT_W = $clog2(adc_pkg::SQRT_STEPS);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [63:0]      rad_q;
  logic [32:0]      rem_q;
  logic [31:0]      root_q;
  logic [34:0]      rem_sh;
  logic [34:0]      trial;
  logic             fits;

  assign rem_sh = {rem_q, rad_q[63:62]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = rem_sh >= trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(adc_pkg::SQRT_STEPS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= {rad_i, 32'h0};
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[61:0], 2'b00};
      if (fits) begin
        rem_q  <= 33'(rem_sh - trial);
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[32:0];
        root_q <= {root_q[30:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

// ===== design/adc_cordic.sv =====
// CORDIC vectoring unit computing atan2(num, den), one rotation per cycle.
module adc_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [adc_pkg::CORDIC_W-1:0] den_i,
  input  logic signed [adc_pkg::CORDIC_W-1:0] num_i,
  output logic                                busy_o,
  output logic signed [adc_pkg::ANG_W-1:0]    ang_o
);

  localparam int unsigned CW = adc_pkg::CORDIC_W;
  localparam int unsigned NW = adc_pkg::CORDIC_CNT_W;

  logic                           busy_q, busy_d;
  logic [NW-1:0]                  cnt_q, cnt_d;
  logic signed [CW-1:0]           den_q, num_q;
  logic signed [adc_pkg::ANG_W-1:0] ang_q;
  logic signed [CW-1:0]           sh_den, sh_num;
  logic signed [adc_pkg::ANG_W-1:0] step;
  logic                           is_zero;

  assign is_zero = (den_i == '0) && (num_i == '0);
  assign sh_den  = den_q >>> cnt_q;
  assign sh_num  = num_q >>> cnt_q;
  assign step    = $signed({2'b00, adc_pkg::atan_entry(5'(cnt_q))});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = !is_zero;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == NW'(adc_pkg::CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (is_zero) begin
        den_q <= den_i;
        num_q <= num_i;
        ang_q <= '0;
      end else if (den_i < 0) begin
        if (num_i >= 0) begin
          den_q <= num_i;
          num_q <= -den_i;
          ang_q <= adc_pkg::ANG_HALF_PI;
        end else begin
          den_q <= -num_i;
          num_q <= den_i;
          ang_q <= -adc_pkg::ANG_HALF_PI;
        end
      end else begin
        den_q <= den_i;
        num_q <= num_i;
        ang_q <= '0;
      end
    end else if (busy_q) begin
      if (num_q > 0) begin
        den_q <= den_q + sh_num;
        num_q <= num_q - sh_den;
        ang_q <= ang_q + step;
      end else begin
        den_q <= den_q - sh_num;
        num_q <= num_q + sh_den;
        ang_q <= ang_q - step;
      end
    end
  end

  assign busy_o = busy_q;
  assign ang_o  = ang_q;

endmodule

// ===== design/adc_datapath.sv =====
// Datapath: operand registers, shared multiplier, checks, drive math, state and result registers.
module adc_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  adc_pkg::cmd_t                        cmd_i,
  output adc_pkg::status_t                     status_o,
  input  logic                                 cfg_valid_i,
  input  logic [1:0]                           cfg_index_i,
  input  logic [15:0]                          cfg_data_i,
  input  logic                                 enable_i,
  input  logic                                 target_tracked_i,
  input  logic signed [15:0]                   dir_x_i,
  input  logic signed [15:0]                   dir_y_i,
  input  logic signed [15:0]                   dir_z_i,
  input  logic signed [15:0]                   current_yaw_i,
  input  logic signed [15:0]                   current_pitch_i,
  input  logic [adc_pkg::ID_WIDTH-1:0]         body_id_i,
  input  logic [adc_pkg::ID_WIDTH-1:0]         item_id_i,
  input  logic [63:0]                          sequence_number_i,
  output logic                                 target_accepted_o,
  output logic                                 ids_captured_o,
  output logic signed [15:0]                   wrapped_yaw_o,
  output logic signed [15:0]                   passed_pitch_o,
  output logic signed [15:0]                   target_yaw_o,
  output logic signed [14:0]                   target_pitch_o,
  output logic signed [15:0]                   yaw_error_o,
  output logic signed [16:0]                   pitch_error_o,
  output logic signed [15:0]                   drive_x_o,
  output logic signed [15:0]                   drive_y_o
);

  localparam int unsigned IW = adc_pkg::ID_WIDTH;
  localparam int unsigned CW = adc_pkg::CORDIC_W;
  localparam int unsigned AW = adc_pkg::ANG_W;
  localparam logic [33:0] ROUND_HALF = 34'd1 << (adc_pkg::ANGLE_FRAC_BITS - 1);

  function automatic logic [16:0] abs16(input logic signed [15:0] v);
    logic signed [16:0] e;
    begin
      e = 17'(v);
      return e[16] ? 17'(-e) : 17'(e);
    end
  endfunction

  // config
  logic [15:0] gain_q;
  logic [14:0] dz_q, limit_q, minh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= 16'd256;
      dz_q    <= 15'd0;
      limit_q <= 15'd32767;
      minh_q  <= 15'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        adc_pkg::CFG_GAIN:     gain_q  <= cfg_data_i;
        adc_pkg::CFG_DEADZONE: dz_q    <= cfg_data_i[14:0];
        adc_pkg::CFG_LIMIT:    limit_q <= cfg_data_i[14:0];
        adc_pkg::CFG_MIN_HOR:  minh_q  <= cfg_data_i[14:0];
        default:               gain_q  <= gain_q;
      endcase
    end
  end

  // request operands
  logic                 en_q, trk_q;
  logic signed [15:0]   x_q, y_q, z_q, cy_q, cp_q;
  logic [IW-1:0]        body_q, item_q;
  logic [63:0]          seq_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      en_q   <= enable_i;
      trk_q  <= target_tracked_i;
      x_q    <= dir_x_i;
      y_q    <= dir_y_i;
      z_q    <= dir_z_i;
      cy_q   <= current_yaw_i;
      cp_q   <= current_pitch_i;
      body_q <= body_id_i;
      item_q <= item_id_i;
      seq_q  <= sequence_number_i;
    end
  end

  // shared multiplier
  logic [29:0]          mul_a;
  logic [16:0]          mul_b;
  logic [46:0]          prod_q;
  logic [31:0]          hsq_q, lsq_q;
  logic [29:0]          mm_q;
  logic [62:0]          p_q;
  logic signed [15:0]   wy_q, ty_q;
  logic signed [AW-1:0] yang_q, tp_q;
  logic signed [15:0]   ye_q;
  logic signed [16:0]   pe_q;
  logic signed [15:0]   dx_q, dy_q;
  logic                 reject_q, capture_q;

  always_comb begin
    unique case (cmd_i.mul_op)
      adc_pkg::MUL_XX:  begin mul_a = 30'(abs16(x_q)); mul_b = abs16(x_q); end
      adc_pkg::MUL_ZZ:  begin mul_a = 30'(abs16(z_q)); mul_b = abs16(z_q); end
      adc_pkg::MUL_YY:  begin mul_a = 30'(abs16(y_q)); mul_b = abs16(y_q); end
      adc_pkg::MUL_MM:  begin mul_a = 30'(minh_q);     mul_b = 17'(minh_q); end
      adc_pkg::MUL_PLO: begin mul_a = mm_q;            mul_b = 17'(lsq_q[15:0]); end
      adc_pkg::MUL_PHI: begin mul_a = mm_q;            mul_b = 17'(lsq_q[31:16]); end
      adc_pkg::MUL_DX:  begin mul_a = 30'(abs16(ye_q)); mul_b = 17'(gain_q); end
      adc_pkg::MUL_DY:  begin
        mul_a = 30'(pe_q[16] ? 17'(-pe_q) : 17'(pe_q));
        mul_b = 17'(gain_q);
      end
      default:          begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= {17'h0, mul_a} * {30'h0, mul_b};
  end

  // iterative units
  logic                 sqrt_busy, cordic_busy;
  logic [31:0]          root;
  logic signed [CW-1:0] cden, cnum;
  logic signed [AW-1:0] cang;
  logic signed [31:0]   xs, ys, zs;

  assign xs = {x_q, 16'h0};
  assign ys = {y_q, 16'h0};
  assign zs = {z_q, 16'h0};
  assign cden = cmd_i.cordic_pitch ? $signed({4'h0, root}) : CW'(zs);
  assign cnum = cmd_i.cordic_pitch ? CW'(ys) : CW'(xs);

  adc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .rad_i   (hsq_q),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  adc_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.cordic_start),
    .den_i   (cden),
    .num_i   (cnum),
    .busy_o  (cordic_busy),
    .ang_o   (cang)
  );

  assign status_o.sqrt_busy   = sqrt_busy;
  assign status_o.cordic_busy = cordic_busy;

  // held state
  logic          ids_valid_q;
  logic [IW-1:0] held_body_q, held_item_q;
  logic [63:0]   last_seq_q;

  // checks
  logic                 hsq_ok, reject_c, capture_c, drive_c;
  logic signed [AW-1:0] ye_full;

  assign hsq_ok = (63'(hsq_q) << (2 * adc_pkg::DIR_FRAC_BITS)) >= p_q;
  assign reject_c = !en_q || !trk_q || (body_q == '0) || (item_q == '0) ||
                    (seq_q == '0) || (lsq_q < adc_pkg::LSQ_LO) ||
                    (lsq_q > adc_pkg::LSQ_HI) || (gain_q == '0) || (limit_q == '0);
  assign capture_c = !ids_valid_q || (held_body_q != body_q) || (held_item_q != item_q);
  assign drive_c   = !capture_c && (last_seq_q != seq_q);
  assign ye_full   = AW'(ty_q) - AW'(wy_q);

  // drive rounding and saturation
  logic [16:0] dmag_in;
  logic        dneg;
  logic [33:0] rnd;
  logic [20:0] qv;
  logic [14:0] sat;
  logic [15:0] dpos;

  assign dmag_in = (cmd_i.take == adc_pkg::TK_DY) ?
                   (pe_q[16] ? 17'(-pe_q) : 17'(pe_q)) : abs16(ye_q);
  assign dneg    = (cmd_i.take == adc_pkg::TK_DY) ? pe_q[16] : ye_q[15];
  assign rnd     = {1'b0, prod_q[32:0]} + ROUND_HALF;
  assign qv      = rnd[33:adc_pkg::ANGLE_FRAC_BITS];
  assign sat     = (dmag_in < 17'(dz_q)) ? 15'd0 :
                   (qv > 21'(limit_q)) ? limit_q : qv[14:0];
  assign dpos    = 16'(sat);

  always_ff @(posedge clk_i) begin
    wy_q <= adc_pkg::wrap_angle(AW'(cy_q));
    case (cmd_i.take)
      adc_pkg::TK_HSQ_SET: hsq_q  <= prod_q[31:0];
      adc_pkg::TK_HSQ_ADD: hsq_q  <= hsq_q + prod_q[31:0];
      adc_pkg::TK_LSQ:     lsq_q  <= hsq_q + prod_q[31:0];
      adc_pkg::TK_MM:      mm_q   <= prod_q[29:0];
      adc_pkg::TK_P_SET:   p_q    <= 63'(prod_q);
      adc_pkg::TK_P_ADD:   p_q    <= p_q + 63'({prod_q, 16'h0});
      adc_pkg::TK_YANG:    yang_q <= cang;
      adc_pkg::TK_TY:      ty_q   <= hsq_ok ? adc_pkg::wrap_angle(yang_q) : wy_q;
      adc_pkg::TK_TP:      tp_q   <= cang;
      adc_pkg::TK_ERR: begin
        reject_q  <= reject_c;
        capture_q <= capture_c;
        ye_q      <= drive_c ? adc_pkg::wrap_angle(ye_full) : 16'sd0;
        pe_q      <= drive_c ? 17'(tp_q) - 17'(cp_q) : 17'sd0;
      end
      adc_pkg::TK_DX:      dx_q <= dneg ? -dpos : dpos;
      adc_pkg::TK_DY:      dy_q <= dneg ? dpos : -dpos;
      default:             ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ids_valid_q <= 1'b0;
      held_body_q <= '0;
      held_item_q <= '0;
      last_seq_q  <= '0;
    end else if (cmd_i.commit) begin
      if (reject_q) begin
        ids_valid_q <= 1'b0;
        held_body_q <= '0;
        held_item_q <= '0;
        last_seq_q  <= '0;
      end else if (capture_q) begin
        ids_valid_q <= 1'b1;
        held_body_q <= body_q;
        held_item_q <= item_q;
        last_seq_q  <= seq_q;
      end else begin
        last_seq_q  <= seq_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      target_accepted_o <= !reject_q;
      ids_captured_o    <= !reject_q && capture_q;
      wrapped_yaw_o     <= reject_q ? 16'sd0 : wy_q;
      passed_pitch_o    <= reject_q ? 16'sd0 : cp_q;
      target_yaw_o      <= reject_q ? 16'sd0 : ty_q;
      target_pitch_o    <= reject_q ? 15'sd0 : tp_q[14:0];
      yaw_error_o       <= reject_q ? 16'sd0 : ye_q;
      pitch_error_o     <= reject_q ? 17'sd0 : pe_q;
      drive_x_o         <= reject_q ? 16'sd0 : dx_q;
      drive_y_o         <= reject_q ? 16'sd0 : dy_q;
    end
  end

endmodule

// ===== design/adc_ctrl.sv =====
// Controller state machine sequencing the datapath for one request at a time.
module adc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  adc_pkg::status_t status_i,
  output adc_pkg::cmd_t    cmd_o
);

  adc_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != adc_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      adc_pkg::ST_IDLE:      if (in_valid_i) state_d = adc_pkg::ST_XX;
      adc_pkg::ST_XX:        state_d = adc_pkg::ST_ZZ;
      adc_pkg::ST_ZZ:        state_d = adc_pkg::ST_YY;
      adc_pkg::ST_YY:        state_d = adc_pkg::ST_MM;
      adc_pkg::ST_MM:        state_d = adc_pkg::ST_MMW;
      adc_pkg::ST_MMW:       state_d = adc_pkg::ST_PLO;
      adc_pkg::ST_PLO:       state_d = adc_pkg::ST_PHI;
      adc_pkg::ST_PHI:       state_d = adc_pkg::ST_PADD;
      adc_pkg::ST_PADD:      state_d = adc_pkg::ST_CYAW;
      adc_pkg::ST_CYAW:      state_d = adc_pkg::ST_CYAW_WAIT;
      adc_pkg::ST_CYAW_WAIT: if (!status_i.cordic_busy) state_d = adc_pkg::ST_SQRT_WAIT;
      adc_pkg::ST_SQRT_WAIT: if (!status_i.sqrt_busy) state_d = adc_pkg::ST_CPIT_WAIT;
      adc_pkg::ST_CPIT_WAIT: if (!status_i.cordic_busy) state_d = adc_pkg::ST_ERR;
      adc_pkg::ST_ERR:       state_d = adc_pkg::ST_DX;
      adc_pkg::ST_DX:        state_d = adc_pkg::ST_DY;
      adc_pkg::ST_DY:        state_d = adc_pkg::ST_DYF;
      adc_pkg::ST_DYF:       state_d = adc_pkg::ST_DONE;
      adc_pkg::ST_DONE:      if (out_free) state_d = adc_pkg::ST_IDLE;
      default:               state_d = adc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load         = 1'b0;
    cmd_o.mul_op       = adc_pkg::MUL_XX;
    cmd_o.take         = adc_pkg::TK_NONE;
    cmd_o.sqrt_start   = 1'b0;
    cmd_o.cordic_start = 1'b0;
    cmd_o.cordic_pitch = 1'b0;
    cmd_o.commit       = 1'b0;
    unique case (state_q)
      adc_pkg::ST_IDLE:  cmd_o.load = in_valid_i;
      adc_pkg::ST_XX:    cmd_o.mul_op = adc_pkg::MUL_XX;
      adc_pkg::ST_ZZ: begin
        cmd_o.mul_op = adc_pkg::MUL_ZZ;
        cmd_o.take   = adc_pkg::TK_HSQ_SET;
      end
      adc_pkg::ST_YY: begin
        cmd_o.mul_op = adc_pkg::MUL_YY;
        cmd_o.take   = adc_pkg::TK_HSQ_ADD;
      end
      adc_pkg::ST_MM: begin
        cmd_o.mul_op     = adc_pkg::MUL_MM;
        cmd_o.take       = adc_pkg::TK_LSQ;
        cmd_o.sqrt_start = 1'b1;
      end
      adc_pkg::ST_MMW:   cmd_o.take = adc_pkg::TK_MM;
      adc_pkg::ST_PLO:   cmd_o.mul_op = adc_pkg::MUL_PLO;
      adc_pkg::ST_PHI: begin
        cmd_o.mul_op = adc_pkg::MUL_PHI;
        cmd_o.take   = adc_pkg::TK_P_SET;
      end
      adc_pkg::ST_PADD:  cmd_o.take = adc_pkg::TK_P_ADD;
      adc_pkg::ST_CYAW:  cmd_o.cordic_start = 1'b1;
      adc_pkg::ST_CYAW_WAIT: begin
        if (!status_i.cordic_busy) cmd_o.take = adc_pkg::TK_YANG;
      end
      adc_pkg::ST_SQRT_WAIT: begin
        cmd_o.take         = adc_pkg::TK_TY;
        cmd_o.cordic_pitch = 1'b1;
        cmd_o.cordic_start = !status_i.sqrt_busy;
      end
      adc_pkg::ST_CPIT_WAIT: begin
        if (!status_i.cordic_busy) cmd_o.take = adc_pkg::TK_TP;
      end
      adc_pkg::ST_ERR:   cmd_o.take = adc_pkg::TK_ERR;
      adc_pkg::ST_DX:    cmd_o.mul_op = adc_pkg::MUL_DX;
      adc_pkg::ST_DY: begin
        cmd_o.mul_op = adc_pkg::MUL_DY;
        cmd_o.take   = adc_pkg::TK_DX;
      end
      adc_pkg::ST_DYF: begin
        cmd_o.mul_op = adc_pkg::MUL_DY;
        cmd_o.take   = adc_pkg::TK_DY;
      end
      adc_pkg::ST_DONE:  cmd_o.commit = out_free;
      default:           cmd_o.load = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= adc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/adc_checker.sv =====
// Port-level assertions for the aim direction correction block, bound to the top level.
module adc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               target_accepted_o,
  input logic               ids_captured_o,
  input logic signed [15:0] wrapped_yaw_o,
  input logic signed [15:0] yaw_error_o,
  input logic signed [16:0] pitch_error_o,
  input logic signed [15:0] drive_x_o,
  input logic signed [15:0] drive_y_o
);

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while another is in flight");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !target_accepted_o) |->
      (!ids_captured_o && wrapped_yaw_o == 0 && yaw_error_o == 0 &&
       pitch_error_o == 0 && drive_x_o == 0 && drive_y_o == 0))
    else $error("rejected result has nonzero fields");

  a_capture_no_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ids_captured_o) |->
      (yaw_error_o == 0 && pitch_error_o == 0 && drive_x_o == 0 && drive_y_o == 0))
    else $error("drive given on identifier capture");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (wrapped_yaw_o <= 16'sd25736 && wrapped_yaw_o > -16'sd25736))
    else $error("wrapped yaw out of range");

  a_pitch_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pitch_error_o > 0) |-> (drive_y_o <= 0))
    else $error("vertical drive sign not inverted");

endmodule

bind aim_direction_correction_top adc_checker u_adc_checker (.*);
